### hdl/lsul_pkg.sv
// ----------------------------------------------------------------------------
// lsul_pkg
// Shared types, sizes and helpers of the load/store lane.
// ----------------------------------------------------------------------------
package lsul_pkg;

    localparam int PIPE_DEPTH    = 2;
    localparam int INGRESS_DEPTH = 4;

    localparam int TAIL      = PIPE_DEPTH - 1;
    localparam int ING_PTR_W = (INGRESS_DEPTH > 1) ? $clog2(INGRESS_DEPTH) : 1;
    localparam int ING_CNT_W = $clog2(INGRESS_DEPTH + 1);
    localparam int ING_SUM_W = ING_CNT_W + 1;

    localparam logic [3:0] MASK_BYTE = 4'h1;
    localparam logic [3:0] MASK_HALF = 4'h3;
    localparam logic [3:0] MASK_WORD = 4'hF;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_STORE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        SIZE_BYTE = 2'd0,
        SIZE_HALF = 2'd1,
        SIZE_WORD = 2'd2
    } size_t;

    typedef struct packed {
        kind_t              kind;
        size_t              size;
        logic               uns;
        logic signed [31:0] offset;
        logic [7:0]         tag;
        logic [63:0]        base;
        logic [63:0]        store_val;
    } op_t;

    typedef struct packed {
        logic               flush;
        logic               issue_valid;
        logic [1:0]         issue_kind;
        logic [1:0]         access_size;
        logic               load_unsigned;
        logic [63:0]        base_value;
        logic signed [31:0] offset;
        logic [63:0]        store_source;
        logic [7:0]         op_tag;
        logic               cache_accept;
        logic               cache_done;
        logic [31:0]        cache_load_word;
    } step_t;

    typedef struct packed {
        logic        wb_valid;
        logic [7:0]  wb_tag;
        logic [63:0] wb_value;
        logic [63:0] wb_address;
        logic [31:0] wb_store_data;
        logic [3:0]  wb_store_mask;
        logic        req_valid;
        logic        req_is_store;
        logic [63:0] req_address;
        logic [31:0] req_data;
        logic [3:0]  req_mask;
    } res_t;

    typedef struct packed {
        logic done;
        logic req_taken;
    } tail_status_t;

    function automatic logic [63:0] extend_load(
        input logic [31:0] word,
        input size_t       size,
        input logic        uns
    );
        logic [63:0] result;
        case (size)
            SIZE_BYTE: result = {{56{word[7] & ~uns}}, word[7:0]};
            SIZE_HALF: result = {{48{word[15] & ~uns}}, word[15:0]};
            default:   result = {{32{word[31]}}, word};
        endcase
        return result;
    endfunction

endpackage

### hdl/load_store_unit_lane_unit.sv
// ----------------------------------------------------------------------------
// load_store_unit_lane_unit
// One issue lane of a load/store unit: ingress FIFO, compacting stages and a
// tail stage that talks to the cache and writes back.
// Registers: two register stages, the input register and then the result
// register; a step moves into the result register when the result side is free.
// Throughput: one step per cycle while the result side is free; the input
// register and result register hold while the result side stalls.
// Reset clears FIFO pointers, stage valid bits, request flag and handshakes.
// ----------------------------------------------------------------------------
module load_store_unit_lane_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_valid,
    output logic               step_stall,
    input  logic               flush,
    input  logic               issue_valid,
    input  logic [1:0]         issue_kind,
    input  logic [1:0]         access_size,
    input  logic               load_unsigned,
    input  logic [63:0]        base_value,
    input  logic signed [31:0] offset,
    input  logic [63:0]        store_source,
    input  logic [7:0]         op_tag,
    input  logic               cache_accept,
    input  logic               cache_done,
    input  logic [31:0]        cache_load_word,
    output logic               result_valid,
    input  logic               result_stall,
    output logic               wb_valid,
    output logic [7:0]         wb_tag,
    output logic [63:0]        wb_value,
    output logic [63:0]        wb_address,
    output logic [31:0]        wb_store_data,
    output logic [3:0]         wb_store_mask,
    output logic               req_valid,
    output logic               req_is_store,
    output logic [63:0]        req_address,
    output logic [31:0]        req_data,
    output logic [3:0]         req_mask
);

    localparam int DEPTH = lsul_pkg::INGRESS_DEPTH;
    localparam int PD    = lsul_pkg::PIPE_DEPTH;
    localparam int PW    = lsul_pkg::ING_PTR_W;
    localparam int CW    = lsul_pkg::ING_CNT_W;
    localparam int SW    = lsul_pkg::ING_SUM_W;

    logic                     step_accept;
    logic                     advance;
    logic                     in_valid_reg;
    lsul_pkg::step_t          in_reg;
    lsul_pkg::step_t          step_item;

    logic                     result_valid_reg;
    lsul_pkg::res_t           res_reg;
    lsul_pkg::res_t           res_next;

    lsul_pkg::op_t            fifo_reg [DEPTH];
    logic [PW-1:0]            head_reg;
    logic [PW-1:0]            head_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            count_pushed;

    lsul_pkg::op_t            stage_op_reg [PD];
    lsul_pkg::op_t            stage_op_next [PD];
    logic [PD-1:0]            stage_valid_reg;
    logic [PD-1:0]            stage_valid_next;
    logic                     sent_reg;
    logic                     sent_next;

    lsul_pkg::op_t            issue_op;
    logic                     push_en;
    logic [SW-1:0]            slot_sum;
    logic [PW-1:0]            push_slot;

    lsul_pkg::res_t           tail_res;
    lsul_pkg::tail_status_t   tail_status;

    assign step_item.flush           = flush;
    assign step_item.issue_valid     = issue_valid;
    assign step_item.issue_kind      = issue_kind;
    assign step_item.access_size     = access_size;
    assign step_item.load_unsigned   = load_unsigned;
    assign step_item.base_value      = base_value;
    assign step_item.offset          = offset;
    assign step_item.store_source    = store_source;
    assign step_item.op_tag          = op_tag;
    assign step_item.cache_accept    = cache_accept;
    assign step_item.cache_done      = cache_done;
    assign step_item.cache_load_word = cache_load_word;

    assign advance     = in_valid_reg && (!result_valid_reg || !result_stall);
    assign step_stall  = in_valid_reg && !advance;
    assign step_accept = step_valid && !step_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (step_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_accept)
        begin
            in_reg <= step_item;
        end
    end

    assign issue_op.kind      = lsul_pkg::kind_t'(in_reg.issue_kind);
    assign issue_op.size      = lsul_pkg::size_t'(in_reg.access_size);
    assign issue_op.uns       = in_reg.load_unsigned;
    assign issue_op.offset    = in_reg.offset;
    assign issue_op.tag       = in_reg.op_tag;
    assign issue_op.base      = in_reg.base_value;
    assign issue_op.store_val = in_reg.store_source;

    lsul_tail u_tail (
        .tail_valid      (stage_valid_reg[lsul_pkg::TAIL]),
        .op              (stage_op_reg[lsul_pkg::TAIL]),
        .request_sent    (sent_reg),
        .cache_accept    (in_reg.cache_accept),
        .cache_done      (in_reg.cache_done),
        .cache_load_word (in_reg.cache_load_word),
        .res             (tail_res),
        .status          (tail_status)
    );

    assign push_en   = in_reg.issue_valid && (count_reg < CW'(DEPTH));
    assign slot_sum  = SW'(head_reg) + SW'(count_reg);
    assign push_slot = (slot_sum >= SW'(DEPTH)) ? PW'(slot_sum - SW'(DEPTH))
                                                : slot_sum[PW-1:0];
    assign count_pushed = count_reg + CW'(push_en);

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        stage_op_next    = stage_op_reg;
        sent_next        = sent_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        res_next         = tail_res;
        if (in_reg.flush)
        begin
            res_next         = '0;
            stage_valid_next = '0;
            sent_next        = 1'b0;
            head_next        = '0;
            count_next       = '0;
        end
        else
        begin
            if (tail_status.req_taken)
            begin
                sent_next = 1'b1;
            end
            if (tail_status.done)
            begin
                stage_valid_next[lsul_pkg::TAIL] = 1'b0;
                sent_next                        = 1'b0;
            end
            for (int d = lsul_pkg::TAIL; d > 0; d--)
            begin
                if (!stage_valid_next[d] && stage_valid_next[d-1])
                begin
                    stage_valid_next[d]   = 1'b1;
                    stage_op_next[d]      = stage_op_next[d-1];
                    stage_valid_next[d-1] = 1'b0;
                    if (d == lsul_pkg::TAIL)
                    begin
                        sent_next = 1'b0;
                    end
                end
            end
            count_next = count_pushed;
            if (!stage_valid_next[0] && (count_pushed != '0))
            begin
                stage_valid_next[0] = 1'b1;
                stage_op_next[0]    = (count_reg == '0) ? issue_op : fifo_reg[head_reg];
                head_next           = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
                count_next          = count_pushed - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= '0;
            sent_reg        <= 1'b0;
            head_reg        <= '0;
            count_reg       <= '0;
        end
        else if (advance)
        begin
            stage_valid_reg <= stage_valid_next;
            sent_reg        <= sent_next;
            head_reg        <= head_next;
            count_reg       <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_op_reg <= stage_op_next;
            if (push_en && !in_reg.flush)
            begin
                fifo_reg[push_slot] <= issue_op;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid  = result_valid_reg;
    assign wb_valid      = res_reg.wb_valid;
    assign wb_tag        = res_reg.wb_tag;
    assign wb_value      = res_reg.wb_value;
    assign wb_address    = res_reg.wb_address;
    assign wb_store_data = res_reg.wb_store_data;
    assign wb_store_mask = res_reg.wb_store_mask;
    assign req_valid     = res_reg.req_valid;
    assign req_is_store  = res_reg.req_is_store;
    assign req_address   = res_reg.req_address;
    assign req_data      = res_reg.req_data;
    assign req_mask      = res_reg.req_mask;

    a_sent_needs_tail: assert property (@(posedge clk) disable iff (!rst_n)
        sent_reg |-> stage_valid_reg[lsul_pkg::TAIL])
        else $error("request flag set with empty tail stage");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("ingress count above depth");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        step_stall |-> (result_valid_reg && result_stall))
        else $error("step stalled without a held result");

    a_wb_mask_legal: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && res_reg.wb_valid && (res_reg.wb_store_mask != '0)) |->
        (res_reg.wb_store_mask == lsul_pkg::MASK_BYTE ||
         res_reg.wb_store_mask == lsul_pkg::MASK_HALF ||
         res_reg.wb_store_mask == lsul_pkg::MASK_WORD))
        else $error("illegal writeback store mask");

endmodule

### hdl/lsul_tail.sv
// ----------------------------------------------------------------------------
// lsul_tail
// Tail stage of the lane: address, cache request and writeback of one op.
// ----------------------------------------------------------------------------
module lsul_tail (
    input  logic                  tail_valid,
    input  lsul_pkg::op_t         op,
    input  logic                  request_sent,
    input  logic                  cache_accept,
    input  logic                  cache_done,
    input  logic [31:0]           cache_load_word,
    output lsul_pkg::res_t        res,
    output lsul_pkg::tail_status_t status
);

    logic [63:0] addr;
    logic [63:0] value;
    logic [31:0] sdata;
    logic [3:0]  smask;

    assign addr = op.base + {{32{op.offset[31]}}, op.offset};

    always_comb
    begin
        res    = '0;
        status = '0;
        value  = '0;
        sdata  = '0;
        smask  = '0;
        if (tail_valid)
        begin
            case (op.kind)
                lsul_pkg::KIND_LOAD:
                begin
                    if (!request_sent)
                    begin
                        res.req_valid    = 1'b1;
                        res.req_address  = addr;
                        status.req_taken = cache_accept;
                    end
                    value       = lsul_pkg::extend_load(cache_load_word, op.size, op.uns);
                    status.done = cache_done;
                end
                lsul_pkg::KIND_STORE:
                begin
                    case (op.size)
                        lsul_pkg::SIZE_BYTE:
                        begin
                            sdata = {24'd0, op.store_val[7:0]};
                            smask = lsul_pkg::MASK_BYTE;
                        end
                        lsul_pkg::SIZE_HALF:
                        begin
                            sdata = {16'd0, op.store_val[15:0]};
                            smask = lsul_pkg::MASK_HALF;
                        end
                        default:
                        begin
                            sdata = op.store_val[31:0];
                            smask = lsul_pkg::MASK_WORD;
                        end
                    endcase
                    if (!request_sent)
                    begin
                        res.req_valid    = 1'b1;
                        res.req_is_store = 1'b1;
                        res.req_address  = addr;
                        res.req_data     = sdata;
                        res.req_mask     = smask;
                        status.req_taken = cache_accept;
                    end
                    status.done = cache_done;
                end
                default:
                begin
                    status.done = 1'b1;
                end
            endcase
            if (status.done)
            begin
                res.wb_valid      = 1'b1;
                res.wb_tag        = op.tag;
                res.wb_value      = value;
                res.wb_address    = addr;
                res.wb_store_data = sdata;
                res.wb_store_mask = smask;
            end
        end
    end

endmodule
